[hdl/hcbp_pkg.sv]
// Shared types, constants and helpers of the Huffman code bit packer.
// No dependencies; imported by every module of the block but hcbp_ram.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int CODE_BITS_W      = 16;
    localparam int CODE_LEN_W       = 5;
    localparam int SYM_W            = 8;
    localparam int NUM_SYMBOLS      = 256;
    localparam int BYTE_W           = 8;
    localparam int PAD_W            = 3;
    localparam int MODE_W           = 2;

    // input tdata layout
    localparam int IN_TDATA_W = 32;
    localparam int IN_SYM_LSB = 0;
    localparam int IN_LEN_LSB = IN_SYM_LSB + SYM_W;
    localparam int IN_BITS_LSB = IN_LEN_LSB + CODE_LEN_W;

    // output tdata layout
    localparam int OUT_TDATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_status;

    // longest code the table holds: parameter limit, capped by code_bits width
    function automatic int f_eff_len(input int max_len);
        return (max_len < CODE_BITS_W) ? max_len : CODE_BITS_W;
    endfunction

endpackage

[hdl/huffman_code_bit_packer_top.sv]
// Encodes and flushes pass the front-end register, the queue, then the output register;
// loads only write the table. One request per cycle in while the queue has room; one
// byte per cycle out while the output is free, so a two-byte encode holds the back end.
// Reset: synchronous, active low; table valid flags clear at once, so all code lengths
// read as zero right after reset without a clearing pass; bit buffer empties.
// Top level of the Huffman code bit packer; depends on hcbp_pkg, hcbp_front,
// hcbp_queue and hcbp_back.
`timescale 1ns / 1ps

module huffman_code_bit_packer_top import hcbp_pkg::*; #(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] symbol, [12:8] code_length, [28:13] code_bits, [31:29] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]      i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] packed_byte, [10:8] pad_bits, [15:11] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] is_final
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    localparam int CW    = f_eff_len(MAX_CODE_LEN);
    localparam int LEN_W = $clog2(CW + 1);
    localparam int CMD_W = 1 + LEN_W + CW;

    t_q_status        q_status;
    logic             push;
    logic [CMD_W-1:0] push_cmd;
    logic             pop;
    logic [CMD_W-1:0] pop_cmd;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_push_cmd      (push_cmd)
    );

    hcbp_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_status    (q_status)
    );

    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (pop_cmd),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[hdl/hcbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/hcbp_front.sv]
// Front end: accepts requests, owns the code table, classifies items into queue commands.
// Depends on hcbp_pkg and hcbp_ram.
`timescale 1ns / 1ps

module hcbp_front import hcbp_pkg::*; #(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    localparam int CW    = f_eff_len(MAX_CODE_LEN),
    localparam int LEN_W = $clog2(CW + 1),
    localparam int ENT_W = LEN_W + CW,
    localparam int CMD_W = 1 + ENT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [MODE_W-1:0]     i_s_axis_tuser,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output logic [CMD_W-1:0]      o_push_cmd
);

    logic                   accept;
    logic [SYM_W-1:0]       in_sym;
    logic [CODE_LEN_W-1:0]  in_len;
    logic [CODE_BITS_W-1:0] in_bits;
    logic [LEN_W-1:0]       len_sat;
    logic                   is_load;
    logic                   is_encode;
    logic                   is_flush;
    logic [ENT_W-1:0]       rd_entry;
    logic [LEN_W-1:0]       rd_len;

    logic [NUM_SYMBOLS-1:0] r_vld;
    logic                   r_vld_q;
    logic                   r_s1_valid;
    logic                   r_s1_flush;

    assign in_sym  = i_s_axis_tdata[IN_SYM_LSB +: SYM_W];
    assign in_len  = i_s_axis_tdata[IN_LEN_LSB +: CODE_LEN_W];
    assign in_bits = i_s_axis_tdata[IN_BITS_LSB +: CODE_BITS_W];

    assign o_s_axis_tready = ({1'b0, i_q_status.count} + (QCNT_W + 1)'(r_s1_valid))
                             < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        unique case (t_mode'(i_s_axis_tuser))
            MODE_LOAD:   is_load   = 1'b1;
            MODE_ENCODE: is_encode = 1'b1;
            MODE_FLUSH:  is_flush  = 1'b1;
            default: ;
        endcase
    end

    assign len_sat = (in_len > CODE_LEN_W'(CW)) ? LEN_W'(CW) : LEN_W'(in_len);

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && is_load),
        .i_waddr (in_sym),
        .i_wdata ({len_sat, in_bits[CW-1:0]}),
        .i_raddr (in_sym),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept && is_load) begin
                r_vld[in_sym] <= 1'b1;
            end
            r_s1_valid <= accept && (is_encode || is_flush);
        end
        r_vld_q    <= r_vld[in_sym];
        r_s1_flush <= is_flush;
    end

    // entry never loaded reads as length zero
    assign rd_len = r_vld_q ? rd_entry[CW +: LEN_W] : '0;

    assign o_push     = r_s1_valid && (r_s1_flush || (rd_len != '0));
    assign o_push_cmd = {r_s1_flush, rd_len, rd_entry[CW-1:0]};

endmodule

[hdl/hcbp_queue.sv]
// Short command queue between front and back end.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_queue import hcbp_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] f_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rp];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_W'(QUEUE_DEPTH)) || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

[hdl/hcbp_back.sv]
// Back end: buffers code bits, emits one byte per cycle unless stalled.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_back import hcbp_pkg::*; #(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    localparam int CW    = f_eff_len(MAX_CODE_LEN),
    localparam int LEN_W = $clog2(CW + 1),
    localparam int CMD_W = 1 + LEN_W + CW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CMD_W-1:0]       i_cmd,
    input  t_q_status              i_q_status,
    output logic                   o_pop,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    localparam int BW    = CW + BYTE_W;
    localparam int CNT_W = $clog2(CW + 2 * BYTE_W);

    logic             cmd_flush;
    logic [LEN_W-1:0] cmd_len;
    logic [CW-1:0]    cmd_bits;
    logic [LEN_W-1:0] sh;
    logic [CW-1:0]    code_la;
    logic [BW-1:0]    placed;
    logic [BW-1:0]    m_buf;
    logic [CNT_W-1:0] m_cnt;
    logic             slot_free;

    logic             emit;
    logic [BYTE_W-1:0] e_byte;
    logic [PAD_W-1:0] e_pad;
    logic             e_fin;
    logic             e_last;

    logic [BW-1:0]    r_buf,   n_buf;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic [PAD_W-1:0] r_o_pad;
    logic             r_o_fin;
    logic             r_o_last;

    assign cmd_flush = i_cmd[CMD_W-1];
    assign cmd_len   = i_cmd[CW +: LEN_W];
    assign cmd_bits  = i_cmd[CW-1:0];

    // left-align the code, then place it after the bits already buffered
    assign sh      = LEN_W'(CW) - cmd_len;
    assign code_la = cmd_bits << sh;
    assign placed  = {code_la, {BYTE_W{1'b0}}} >> r_cnt[PAD_W-1:0];
    assign m_buf   = r_buf | placed;
    assign m_cnt   = r_cnt + CNT_W'(cmd_len);

    assign slot_free = !r_o_valid || i_m_axis_tready;

    always_comb begin
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        o_pop  = 1'b0;
        emit   = 1'b0;
        e_byte = r_buf[BW-1 -: BYTE_W];
        e_pad  = '0;
        e_fin  = 1'b0;
        e_last = 1'b0;
        if (slot_free) begin
            if (r_cnt >= CNT_W'(BYTE_W)) begin
                emit   = 1'b1;
                e_last = r_cnt < CNT_W'(2 * BYTE_W);
                n_buf  = r_buf << BYTE_W;
                n_cnt  = r_cnt - CNT_W'(BYTE_W);
            end else if (!i_q_status.empty) begin
                o_pop = 1'b1;
                if (cmd_flush) begin
                    if (r_cnt != '0) begin
                        emit   = 1'b1;
                        e_pad  = PAD_W'((PAD_W + 1)'(BYTE_W) - {1'b0, r_cnt[PAD_W-1:0]});
                        e_fin  = 1'b1;
                        e_last = 1'b1;
                    end
                    n_buf = '0;
                    n_cnt = '0;
                end else if (m_cnt >= CNT_W'(BYTE_W)) begin
                    emit   = 1'b1;
                    e_byte = m_buf[BW-1 -: BYTE_W];
                    e_last = m_cnt < CNT_W'(2 * BYTE_W);
                    n_buf  = m_buf << BYTE_W;
                    n_cnt  = m_cnt - CNT_W'(BYTE_W);
                end else begin
                    n_buf = m_buf;
                    n_cnt = m_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_o_byte <= e_byte;
            r_o_pad  <= e_pad;
            r_o_fin  <= e_fin;
            r_o_last <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - PAD_W - BYTE_W){1'b0}}, r_o_pad, r_o_byte};
    assign o_m_axis_tuser  = r_o_fin;
    assign o_m_axis_tlast  = r_o_last;

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_fin) |-> (r_o_last && (r_o_pad != '0)))
        else $error("final byte without tlast or padding");

    a_pad_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_fin) |-> (r_o_pad == '0))
        else $error("padding on a non-final byte");

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BW))
        else $error("bit buffer overrun");

endmodule

[dv/tb_huffman_code_bit_packer_top.sv]
// Testbench of huffman_code_bit_packer_top: directed and random load/encode/flush requests.
// A behavioral copy of the code table and bit packer predicts every output byte.
// Depends on hcbp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_top;
    import hcbp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int LONGEST_CODE = (MAX_CODE_LEN_DEF < CODE_BITS_W) ? MAX_CODE_LEN_DEF
                                                                    : CODE_BITS_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [PAD_W-1:0]  pad;
        logic              is_final;
        logic              last;
    } packed_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // predictor state
    logic [CODE_LEN_W-1:0]  code_len_tbl [NUM_SYMBOLS];
    logic [CODE_BITS_W-1:0] code_bits_tbl[NUM_SYMBOLS];
    logic [BYTE_W-1:0]      acc_byte = '0;
    logic [PAD_W-1:0]       fill_pos = '0;
    packed_result_t         pending_bytes[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned n_loads = 0, n_encodes = 0, n_flushes = 0, n_ignored = 0;
    int unsigned n_bytes = 0, n_finals = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    bit          no_idle = 1'b0;

    huffman_code_bit_packer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                     pending_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge i_clk) begin : check_bytes
        packed_result_t got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{out_byte: m_tdata[BYTE_W-1:0], pad: m_tdata[BYTE_W +: PAD_W],
                    is_final: m_tuser, last: m_tlast};
            n_bytes++;
            if (got.is_final) n_finals++;
            if (pending_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte: got byte=%02h pad=%0d final=%0b last=%0b",
                         $time, got.out_byte, got.pad, got.is_final, got.last);
            end else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch: expected byte=%02h pad=%0d final=%0b last=%0b",
                             $time, want.out_byte, want.pad, want.is_final, want.last);
                    $display("%0t:           actual   byte=%02h pad=%0d final=%0b last=%0b",
                             $time, got.out_byte, got.pad, got.is_final, got.last);
                end
            end
        end
    end

    task automatic predict_packer(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                                  input logic [CODE_LEN_W-1:0] len,
                                  input logic [CODE_BITS_W-1:0] bits);
        int n;
        int made;
        logic [CODE_BITS_W-1:0] code;
        packed_result_t r;
        made = 0;
        case (mode)
            MODE_LOAD: begin
                n_loads++;
                code_len_tbl[sym]  = (len > LONGEST_CODE) ? CODE_LEN_W'(LONGEST_CODE) : len;
                code_bits_tbl[sym] = bits;
            end
            MODE_ENCODE: begin
                n_encodes++;
                n = code_len_tbl[sym];
                code = code_bits_tbl[sym];
                for (int j = n - 1; j >= 0; j--) begin
                    if (code[j]) acc_byte[3'd7 - fill_pos] = 1'b1;
                    if (fill_pos == 3'd7) begin
                        pending_bytes.push_back('{out_byte: acc_byte, pad: '0,
                                                  is_final: 1'b0, last: 1'b0});
                        made++;
                        acc_byte = '0;
                        fill_pos = '0;
                    end else begin
                        fill_pos++;
                    end
                end
                if (made > 0) begin
                    r = pending_bytes.pop_back();
                    r.last = 1'b1;
                    pending_bytes.push_back(r);
                end
            end
            MODE_FLUSH: begin
                n_flushes++;
                if (fill_pos != 0) begin
                    pending_bytes.push_back('{out_byte: acc_byte, pad: PAD_W'(8 - fill_pos),
                                              is_final: 1'b1, last: 1'b1});
                    acc_byte = '0;
                    fill_pos = '0;
                end
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                                input logic [CODE_LEN_W-1:0] len,
                                input logic [CODE_BITS_W-1:0] bits);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 7) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, bits, len, sym};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_packer(mode, sym, len, bits);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CODE_LEN_W-1:0] pick_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return CODE_LEN_W'($urandom_range(1, 9));
        if (r < 85) return CODE_LEN_W'($urandom_range(10, 16));
        if (r < 95) return CODE_LEN_W'($urandom_range(17, 31));
        return '0;
    endfunction

    task automatic test_cleared_table();
        send_request(MODE_ENCODE, 8'h55, 5'd0, 16'h0000);
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_request(MODE_LOAD, 8'h00, 5'd16, 16'hFFFF);
        send_request(MODE_LOAD, 8'hFF, 5'd1, 16'h0000);
        send_request(MODE_LOAD, 8'h80, 5'd31, 16'hA5C3);
        send_request(MODE_LOAD, 8'h01, 5'd17, 16'h0001);
        send_request(MODE_LOAD, 8'h02, 5'd0, 16'hFFFF);
        send_request(MODE_LOAD, 8'h03, 5'd8, 16'h005A);
        send_request(MODE_ENCODE, 8'h00, 5'd0, 16'h0000);
        send_request(MODE_ENCODE, 8'hFF, 5'd31, 16'hFFFF);
        send_request(MODE_ENCODE, 8'h80, 5'd0, 16'h0000);
        send_request(MODE_ENCODE, 8'h01, 5'd0, 16'h0000);
        send_request(MODE_ENCODE, 8'h02, 5'd0, 16'h0000);
        send_request(MODE_IGNORED, 8'hFF, 5'd31, 16'hFFFF);
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        send_request(MODE_ENCODE, 8'h03, 5'd0, 16'h0000);
        send_request(MODE_ENCODE, 8'hFF, 5'd0, 16'h0000);
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        wait_drained();
    endtask

    // receiver held off while long codes keep coming, so the input stalls
    task automatic test_backpressure();
        send_request(MODE_LOAD, 8'h41, 5'd15, 16'($urandom));
        send_request(MODE_LOAD, 8'h42, 5'd13, 16'($urandom));
        hold_request = 400;
        for (int i = 0; i < 40; i++)
            send_request(MODE_ENCODE, (i % 2) ? 8'h42 : 8'h41, 5'd0, 16'h0000);
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        wait_drained();
    endtask

    task automatic test_random_stream(input int n_items);
        logic [SYM_W-1:0] alphabet[24];
        int sent;
        int r;
        sent = 0;
        foreach (alphabet[k]) begin
            alphabet[k] = 8'($urandom);
            send_request(MODE_LOAD, alphabet[k], pick_code_len(), 16'($urandom));
            sent++;
        end
        while (sent < n_items) begin
            no_idle = (sent >= 100 && sent < 180);
            r = $urandom_range(0, 99);
            if (r < 70)
                send_request(MODE_ENCODE, alphabet[$urandom_range(0, 23)], 5'($urandom),
                             16'($urandom));
            else if (r < 76)
                send_request(MODE_ENCODE, 8'($urandom), 5'($urandom), 16'($urandom));
            else if (r < 84)
                send_request(MODE_FLUSH, 8'($urandom), 5'($urandom), 16'($urandom));
            else if (r < 92)
                send_request(MODE_LOAD, alphabet[$urandom_range(0, 23)], pick_code_len(),
                             16'($urandom));
            else if (r < 96)
                send_request(MODE_LOAD, 8'($urandom), 5'($urandom), 16'($urandom));
            else
                send_request(MODE_IGNORED, 8'($urandom), 5'($urandom), 16'($urandom));
            if (r < 96) sent++;
        end
        no_idle = 1'b0;
        send_request(MODE_FLUSH, 8'h00, 5'd0, 16'h0000);
        wait_drained();
    endtask

    initial begin
        foreach (code_len_tbl[k]) begin
            code_len_tbl[k]  = '0;
            code_bits_tbl[k] = '0;
        end
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_field_extremes();
        test_backpressure();
        test_random_stream(250);

        $display("Sent %0d loads, %0d encodes, %0d flushes and %0d ignored requests;",
                 n_loads, n_encodes, n_flushes, n_ignored);
        $display("checked %0d output bytes, %0d of them final, with stalls on both sides.",
                 n_bytes, n_finals);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
